@@ rtl/aards_pkg.sv @@
// ----------------------------------------------------------------------------
// Area-average RGB downscaler package
// Shared widths, register indexes, luma coefficients and the contrast table.
// ----------------------------------------------------------------------------
package aards_pkg;

  localparam int CH_W      = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = 12;
  localparam int CONTR_W   = 7;
  localparam int GAIN_W    = 18;
  // Per-channel accumulator width: one frame needs 32 bits, the rest is headroom
  // for entries that are never emitted and keep growing.
  localparam int SUM_W     = 48;

  localparam int DEF_MAX_SOURCE_WIDTH  = 4096;
  localparam int DEF_MAX_SOURCE_HEIGHT = 4096;
  localparam int DEF_MAX_TARGET_WIDTH  = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST_LEVEL = 3'd4;

  localparam int CONTRAST_MAX = 100;

  // Q0.16 luma coefficients and the mid level 127.5 in Q8.16.
  localparam int LUMA_COEF_R = 13933;
  localparam int LUMA_COEF_G = 46871;
  localparam int LUMA_COEF_B = 4732;
  localparam int LUMA_MID    = 8355840;

  // Contrast gain 2^(level/50) - 1 in Q2.16.
  localparam logic [GAIN_W-1:0] CONTRAST_ROM [0:CONTRAST_MAX] = '{
    18'd0, 18'd915, 18'd1842, 18'd2783, 18'd3737, 18'd4704, 18'd5684, 18'd6678,
    18'd7687, 18'd8709, 18'd9745, 18'd10796, 18'd11862, 18'd12942, 18'd14037,
    18'd15148, 18'd16275, 18'd17417, 18'd18575, 18'd19749, 18'd20939, 18'd22146,
    18'd23370, 18'd24612, 18'd25870, 18'd27146, 18'd28440, 18'd29752, 18'd31082,
    18'd32430, 18'd33798, 18'd35185, 18'd36591, 18'd38016, 18'd39462, 18'd40928,
    18'd42414, 18'd43921, 18'd45449, 18'd46998, 18'd48569, 18'd50162, 18'd51777,
    18'd53414, 18'd55075, 18'd56759, 18'd58466, 18'd60197, 18'd61952, 18'd63732,
    18'd65536, 18'd67366, 18'd69221, 18'd71102, 18'd73009, 18'd74943, 18'd76905,
    18'd78893, 18'd80909, 18'd82953, 18'd85026, 18'd87128, 18'd89259, 18'd91420,
    18'd93611, 18'd95833, 18'd98085, 18'd100369, 18'd102685, 18'd105034,
    18'd107415, 18'd109829, 18'd112277, 18'd114759, 18'd117276, 18'd119828,
    18'd122415, 18'd125039, 18'd127699, 18'd130397, 18'd133132, 18'd135905,
    18'd138717, 18'd141569, 18'd144460, 18'd147391, 18'd150363, 18'd153377,
    18'd156433, 18'd159532, 18'd162674, 18'd165859, 18'd169089, 18'd172365,
    18'd175686, 18'd179053, 18'd182467, 18'd185929, 18'd189440, 18'd192999,
    18'd196608
  };

  function automatic logic [GAIN_W-1:0] contrast_gain(input logic [CONTR_W-1:0] level);
    logic [GAIN_W-1:0] g;
    g = '0;
    if (32'(level) <= CONTRAST_MAX) begin
      g = CONTRAST_ROM[level];
    end
    return g;
  endfunction

  // Channel plus centred luma times gain, rounded half up and clamped to 0..255.
  function automatic logic [CH_W-1:0] adjust_channel(input logic [CH_W-1:0] ch,
                                                     input logic signed [43:0] prod);
    logic signed [45:0] s;
    logic signed [45:0] t;
    logic [13:0]        r;
    logic [CH_W-1:0]    y;
    s = $signed({6'b0, ch, 32'b0}) + 46'(prod);
    t = s + 46'sd2147483648;
    r = t[45:32];
    if (s <= 46'sd0) begin
      y = '0;
    end else if (r > 14'd255) begin
      y = 8'hFF;
    end else begin
      y = r[7:0];
    end
    return y;
  endfunction

endpackage

@@ rtl/aards_pix_if.sv @@
// ----------------------------------------------------------------------------
// Source pixel channel
// Valid/ready channel that carries one RGB source pixel per transaction.
// ----------------------------------------------------------------------------
interface aards_pix_if;
  import aards_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source(output valid, output red_in, output green_in, output blue_in,
                 input ready);
  modport sink(input valid, input red_in, input green_in, input blue_in,
               output ready);
endinterface

@@ rtl/aards_res_if.sv @@
// ----------------------------------------------------------------------------
// Target pixel channel
// Valid/ready channel that carries one averaged target pixel per transaction.
// ----------------------------------------------------------------------------
interface aards_res_if;
  import aards_pkg::*;

  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    red_out;
  logic [CH_W-1:0]    green_out;
  logic [CH_W-1:0]    blue_out;
  logic [COORD_W-1:0] out_column;
  logic [COORD_W-1:0] out_row;
  logic               frame_done;

  modport source(output valid, output red_out, output green_out, output blue_out,
                 output out_column, output out_row, output frame_done, input ready);
  modport sink(input valid, input red_out, input green_out, input blue_out,
               input out_column, input out_row, input frame_done, output ready);
endinterface

@@ rtl/aards_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module aards_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ rtl/area_average_rgb_downscaler_top.sv @@
// ----------------------------------------------------------------------------
// Area-average RGB downscaler
// Contrast boost, area-weighted accumulation into two banked target rows kept
// in one RAM, and a rounded division of each finished target pixel.
// ----------------------------------------------------------------------------
// One source pixel is taken at a time: a new pixel is accepted only once the last
//   has passed every step, with one read-modify-write of the accumulator RAM per
//   target cell it touches (up to four). A pixel that completes a target pixel
//   also runs the 8-step restoring divider, and its result is registered once the
//   result register is free, later while that register still waits on ready.
// Reset (synchronous, active high) and every write to a defined register restart
//   the frame and clear all 2*MAX_TARGET_WIDTH RAM entries; no pixel is taken then.
module area_average_rgb_downscaler_top #(
  parameter int MAX_SOURCE_WIDTH  = aards_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = aards_pkg::DEF_MAX_SOURCE_HEIGHT,
  parameter int MAX_TARGET_WIDTH  = aards_pkg::DEF_MAX_TARGET_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [aards_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aards_pkg::CFG_W-1:0]     cfg_data,
  aards_pix_if.sink                      pix,
  aards_res_if.source                    res
);
  import aards_pkg::*;

  localparam int DEPTH  = 2 * MAX_TARGET_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int WORD_W = 3 * SUM_W;
  localparam int PCNT_W = 2 * CFG_W;
  localparam int WGT_W  = 2 * CFG_W;
  localparam int ADD_W  = CH_W + WGT_W;
  localparam int NUM_W  = SUM_W + 1;

  // The sequencer walks one source pixel at a time through these steps.
  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_LUMA     = 13'b0000000000100,
    S_GAIN     = 13'b0000000001000,
    S_ADJ      = 13'b0000000010000,
    S_ACC_RD   = 13'b0000000100000,
    S_ACC_MUL  = 13'b0000001000000,
    S_ACC_WR   = 13'b0000010000000,
    S_EM_RD    = 13'b0000100000000,
    S_DIV_INIT = 13'b0001000000000,
    S_DIV      = 13'b0010000000000,
    S_EMIT     = 13'b0100000000000,
    S_NEXT     = 13'b1000000000000
  } state_t;

  state_t state;

  // Configuration registers and values derived from them.
  logic [CFG_W-1:0]   source_width;
  logic [CFG_W-1:0]   source_height;
  logic [CFG_W-1:0]   target_width;
  logic [CFG_W-1:0]   target_height;
  logic [CONTR_W-1:0] contrast_level;
  logic               sizes_ok;
  logic [PCNT_W-1:0]  pixel_count;
  logic               cfg_hit;

  // Source position and the incremental target position along each axis.
  // The remainder is the source pixel's start offset inside its first target cell.
  logic [CFG_W-1:0] sx;
  logic [CFG_W-1:0] sy;
  logic [CFG_W-1:0] col_tx;
  logic [CFG_W-1:0] col_rem;
  logic [CFG_W-1:0] row_ty;
  logic [CFG_W-1:0] row_rem;

  // Pixel data path.
  logic [CH_W-1:0]         px_r, px_g, px_b;
  logic signed [24:0]      luma;
  logic [GAIN_W-1:0]       gain;
  logic signed [43:0]      prod;
  logic [CH_W-1:0]         adj_r, adj_g, adj_b;
  logic                    sel_c, sel_r;
  logic [WGT_W-1:0]        weight;
  logic [ADD_W-1:0]        add_r, add_g, add_b;

  // Divider.
  logic [NUM_W-1:0] rem_r, rem_g, rem_b;
  logic [CH_W-1:0]  q_r, q_g, q_b;
  logic             sat_r, sat_g, sat_b;
  logic [2:0]       div_cnt;

  // Result register.
  logic               out_valid;
  logic [CH_W-1:0]    out_red, out_green, out_blue;
  logic [COORD_W-1:0] out_col, out_rw;
  logic               out_done;
  logic               out_free;

  // RAM ports.
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;
  logic [AW-1:0]     clear_addr;

  // Geometry of the current source pixel.
  logic [CFG_W:0]   col_span, row_span;
  logic             col_two, row_two, col_end, row_end;
  logic [CFG_W-1:0] hw0, hw1, vw0, vw1;
  logic [CFG_W-1:0] cur_tx, cur_ty;
  logic [AW-1:0]    acc_addr, em_addr;
  logic [NUM_W-1:0] div_den;
  logic [NUM_W-1:0] num_r, num_g, num_b;
  logic [NUM_W-1:0] sat_lim;

  assign cfg_hit = (cfg_index == REG_SOURCE_WIDTH) || (cfg_index == REG_SOURCE_HEIGHT) ||
                   (cfg_index == REG_TARGET_WIDTH) || (cfg_index == REG_TARGET_HEIGHT) ||
                   (cfg_index == REG_CONTRAST_LEVEL);

  // A source pixel covers [rem, rem + tw) in units where a target cell is sw wide.
  // It spills into a second cell when that span passes the cell end, and closes
  // its first cell when the span ends exactly on the boundary.
  assign col_span = {1'b0, col_rem} + {1'b0, target_width};
  assign row_span = {1'b0, row_rem} + {1'b0, target_height};
  assign col_two  = col_span > {1'b0, source_width};
  assign row_two  = row_span > {1'b0, source_height};
  assign col_end  = col_span == {1'b0, source_width};
  assign row_end  = row_span == {1'b0, source_height};
  assign hw0      = col_two ? (source_width - col_rem) : target_width;
  assign hw1      = CFG_W'(col_span - {1'b0, source_width});
  assign vw0      = row_two ? (source_height - row_rem) : target_height;
  assign vw1      = CFG_W'(row_span - {1'b0, source_height});

  // Target rows alternate between two banks by parity.
  assign cur_tx   = col_tx + CFG_W'(sel_c);
  assign cur_ty   = row_ty + CFG_W'(sel_r);
  assign acc_addr = (cur_ty[0] ? AW'(MAX_TARGET_WIDTH) : AW'(0)) + AW'(cur_tx);
  assign em_addr  = (row_ty[0] ? AW'(MAX_TARGET_WIDTH) : AW'(0)) + AW'(col_tx);

  // Rounded division: (sum + d/2) / d, saturating when the quotient reaches 256.
  assign num_r   = NUM_W'(mem_rdata[3*SUM_W-1:2*SUM_W]) + NUM_W'(pixel_count >> 1);
  assign num_g   = NUM_W'(mem_rdata[2*SUM_W-1:SUM_W]) + NUM_W'(pixel_count >> 1);
  assign num_b   = NUM_W'(mem_rdata[SUM_W-1:0]) + NUM_W'(pixel_count >> 1);
  assign sat_lim = NUM_W'(pixel_count) << 8;
  assign div_den = NUM_W'(pixel_count) << div_cnt;

  assign out_free = !out_valid || res.ready;
  assign pix.ready = (state == S_IDLE);

  // RAM port selection: the clearing sweep, accumulation read and write-back, the
  // emission read, and the clearing of an entry as it is emitted.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clear_addr;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = acc_addr;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_ACC_RD: begin
        mem_re = 1'b1;
      end
      S_ACC_WR: begin
        mem_we    = 1'b1;
        mem_waddr = acc_addr;
        mem_wdata = {mem_rdata[3*SUM_W-1:2*SUM_W] + SUM_W'(add_r),
                     mem_rdata[2*SUM_W-1:SUM_W] + SUM_W'(add_g),
                     mem_rdata[SUM_W-1:0] + SUM_W'(add_b)};
      end
      S_EM_RD: begin
        mem_re    = 1'b1;
        mem_raddr = em_addr;
      end
      S_EMIT: begin
        mem_we    = out_free;
        mem_waddr = em_addr;
      end
      default: begin
      end
    endcase
  end

  aards_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_row_sums (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Configuration registers. The size check and pixel count settle during the
  // clearing sweep that every write to a defined register starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width   <= CFG_W'(1);
      source_height  <= CFG_W'(1);
      target_width   <= CFG_W'(1);
      target_height  <= CFG_W'(1);
      contrast_level <= '0;
      sizes_ok       <= 1'b0;
      pixel_count    <= PCNT_W'(1);
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SOURCE_WIDTH:   source_width   <= cfg_data;
          REG_SOURCE_HEIGHT:  source_height  <= cfg_data;
          REG_TARGET_WIDTH:   target_width   <= cfg_data;
          REG_TARGET_HEIGHT:  target_height  <= cfg_data;
          REG_CONTRAST_LEVEL: contrast_level <= cfg_data[CONTR_W-1:0];
          default: begin
          end
        endcase
      end
      sizes_ok <= (source_width != '0) && (source_height != '0) &&
                  (target_width != '0) && (target_height != '0) &&
                  (target_width <= source_width) && (target_height <= source_height) &&
                  (32'(source_width) <= MAX_SOURCE_WIDTH) &&
                  (32'(source_height) <= MAX_SOURCE_HEIGHT) &&
                  (32'(target_width) <= MAX_TARGET_WIDTH) &&
                  (32'(contrast_level) <= CONTRAST_MAX);
      pixel_count <= PCNT_W'(source_width) * PCNT_W'(source_height);
    end
  end

  // Sequencer, position tracking and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
      sx         <= '0;
      sy         <= '0;
      col_tx     <= '0;
      col_rem    <= '0;
      row_ty     <= '0;
      row_rem    <= '0;
      sel_c      <= 1'b0;
      sel_r      <= 1'b0;
      div_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + AW'(1);
          if (clear_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pix.valid && sizes_ok) begin
            px_r  <= pix.red_in;
            px_g  <= pix.green_in;
            px_b  <= pix.blue_in;
            state <= S_LUMA;
          end
        end
        S_LUMA: begin
          luma <= $signed(25'(LUMA_COEF_R * 32'(px_r) + LUMA_COEF_G * 32'(px_g) +
                              LUMA_COEF_B * 32'(px_b)) - 25'(LUMA_MID));
          gain  <= contrast_gain(contrast_level);
          state <= S_GAIN;
        end
        S_GAIN: begin
          prod  <= 44'(luma) * 44'($signed({1'b0, gain}));
          state <= S_ADJ;
        end
        S_ADJ: begin
          adj_r <= adjust_channel(px_r, prod);
          adj_g <= adjust_channel(px_g, prod);
          adj_b <= adjust_channel(px_b, prod);
          sel_c <= 1'b0;
          sel_r <= 1'b0;
          state <= S_ACC_RD;
        end
        S_ACC_RD: begin
          weight <= WGT_W'(sel_c ? hw1 : hw0) * WGT_W'(sel_r ? vw1 : vw0);
          state  <= S_ACC_MUL;
        end
        S_ACC_MUL: begin
          add_r <= ADD_W'(adj_r) * ADD_W'(weight);
          add_g <= ADD_W'(adj_g) * ADD_W'(weight);
          add_b <= ADD_W'(adj_b) * ADD_W'(weight);
          state <= S_ACC_WR;
        end
        S_ACC_WR: begin
          // Cells are visited column first, then the second row if there is one.
          if (!sel_c && col_two) begin
            sel_c <= 1'b1;
            state <= S_ACC_RD;
          end else if (!sel_r && row_two) begin
            sel_c <= 1'b0;
            sel_r <= 1'b1;
            state <= S_ACC_RD;
          end else if (col_end && row_end) begin
            state <= S_EM_RD;
          end else begin
            state <= S_NEXT;
          end
        end
        S_EM_RD: begin
          state <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          rem_r   <= num_r;
          rem_g   <= num_g;
          rem_b   <= num_b;
          sat_r   <= num_r >= sat_lim;
          sat_g   <= num_g >= sat_lim;
          sat_b   <= num_b >= sat_lim;
          div_cnt <= 3'd7;
          state   <= S_DIV;
        end
        S_DIV: begin
          // One quotient bit per channel and cycle, most significant first.
          if (rem_r >= div_den) begin
            rem_r <= rem_r - div_den;
          end
          if (rem_g >= div_den) begin
            rem_g <= rem_g - div_den;
          end
          if (rem_b >= div_den) begin
            rem_b <= rem_b - div_den;
          end
          q_r     <= {q_r[CH_W-2:0], rem_r >= div_den};
          q_g     <= {q_g[CH_W-2:0], rem_g >= div_den};
          q_b     <= {q_b[CH_W-2:0], rem_b >= div_den};
          div_cnt <= div_cnt - 3'd1;
          if (div_cnt == 3'd0) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_red   <= sat_r ? 8'hFF : q_r;
            out_green <= sat_g ? 8'hFF : q_g;
            out_blue  <= sat_b ? 8'hFF : q_b;
            out_col   <= col_tx[COORD_W-1:0];
            out_rw    <= row_ty[COORD_W-1:0];
            out_done  <= (col_tx == target_width - CFG_W'(1)) &&
                         (row_ty == target_height - CFG_W'(1));
            state     <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (sx + CFG_W'(1) == source_width) begin
            sx      <= '0;
            col_tx  <= '0;
            col_rem <= '0;
            if (sy + CFG_W'(1) == source_height) begin
              sy      <= '0;
              row_ty  <= '0;
              row_rem <= '0;
            end else begin
              sy <= sy + CFG_W'(1);
              if (row_span >= {1'b0, source_height}) begin
                row_ty  <= row_ty + CFG_W'(1);
                row_rem <= CFG_W'(row_span - {1'b0, source_height});
              end else begin
                row_rem <= row_span[CFG_W-1:0];
              end
            end
          end else begin
            sx <= sx + CFG_W'(1);
            if (col_span >= {1'b0, source_width}) begin
              col_tx  <= col_tx + CFG_W'(1);
              col_rem <= CFG_W'(col_span - {1'b0, source_width});
            end else begin
              col_rem <= col_span[CFG_W-1:0];
            end
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
      // A write to a defined register restarts the frame and sweeps the accumulators.
      if (cfg_write && cfg_hit) begin
        state      <= S_CLEAR;
        clear_addr <= '0;
        sx         <= '0;
        sy         <= '0;
        col_tx     <= '0;
        col_rem    <= '0;
        row_ty     <= '0;
        row_rem    <= '0;
      end
    end
  end

  assign res.valid      = out_valid;
  assign res.red_out    = out_red;
  assign res.green_out  = out_green;
  assign res.blue_out   = out_blue;
  assign res.out_column = out_col;
  assign res.out_row    = out_rw;
  assign res.frame_done = out_done;

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg_hit) |=> (state == S_CLEAR && clear_addr == '0))
    else $error("register write did not start the clearing sweep");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> res.valid)
    else $error("emitted target pixel not presented");

  a_single_port: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("accumulator RAM read and written in the same cycle");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == 3'd0 && !cfg_write) |=> (state == S_EMIT))
    else $error("divider did not finish after eight steps");

endmodule
